/* hdl/qfl_pkg.sv */
package qfl_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
    localparam int BYTES = 8;
    localparam int CNT_W = $clog2(BYTES);

    typedef struct packed {
        logic        load;
        logic        first;
        logic [63:0] q;
    } fold_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_QUANT = 4'b0010,
        ST_FOLD  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    // The prime is 2^40 + 2^8 + 0xB3, so the product is two shifts and a narrow multiply.
    function automatic logic [63:0] fnv_step(input logic [63:0] acc, input logic [7:0] b);
        logic [63:0] x;
        logic [63:0] lo;
        x = acc ^ {56'd0, b};
        lo = x * {56'd0, FNV_PRIME[7:0]};
        return (x << 40) + (x << 8) + lo;
    endfunction

endpackage

/* hdl/qfl_quant.sv */
module qfl_quant (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] value_bits,
    output logic        q_valid,
    output logic [63:0] q
);
    import qfl_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_sign_reg;
    logic        s1_nan_reg;
    logic        s1_inf_reg;
    logic        s1_tiny_reg;
    logic [10:0] s1_exp_reg;
    logic [62:0] s1_prod_reg;

    logic        s2_valid_reg, s2_valid_next;
    logic        s2_sign_reg;
    logic        s2_nan_reg;
    logic        s2_inf_reg;
    logic        s2_tiny_reg;
    logic signed [11:0] s2_e_reg;
    logic [52:0] s2_m_reg;

    logic        q_valid_reg, q_valid_next;
    logic [63:0] q_reg, q_next;

    logic [52:0] m_in;
    logic [62:0] prod;
    logic [52:0] keep;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [53:0] rsum;
    logic signed [11:0] ebias;
    logic [52:0] m_next;
    logic signed [11:0] e_next;
    logic [5:0]  shr;
    logic [52:0] shifted;
    logic [52:0] rtap;
    logic [63:0] mag;
    logic signed [11:0] e_neg;

    assign m_in = {1'b1, value_bits[51:0]};
    assign prod = {m_in, 10'd0} - {6'd0, m_in, 4'd0} - {7'd0, m_in, 3'd0};

    always_comb begin
        if (s1_prod_reg[62]) begin
            keep   = s1_prod_reg[62:10];
            guard  = s1_prod_reg[9];
            sticky = |s1_prod_reg[8:0];
            ebias  = $signed({1'b0, s1_exp_reg}) - 12'sd1065;
        end else begin
            keep   = s1_prod_reg[61:9];
            guard  = s1_prod_reg[8];
            sticky = |s1_prod_reg[7:0];
            ebias  = $signed({1'b0, s1_exp_reg}) - 12'sd1066;
        end
        round_up = guard & (sticky | keep[0]);
        rsum = {1'b0, keep} + {53'd0, round_up};
        if (rsum[53]) begin
            m_next = rsum[53:1];
            e_next = ebias + 12'sd1;
        end else begin
            m_next = rsum[52:0];
            e_next = ebias;
        end
    end

    always_comb begin
        e_neg   = -s2_e_reg;
        shr     = e_neg[5:0];
        shifted = s2_m_reg >> shr;
        rtap    = s2_m_reg >> (shr - 6'd1);
        if (s2_e_reg >= 12'sd0) begin
            mag = {11'd0, s2_m_reg} << s2_e_reg[3:0];
        end else begin
            mag = {11'd0, shifted} + {63'd0, rtap[0]};
        end
        if (s2_nan_reg) begin
            q_next = 64'd0;
        end else if (s2_inf_reg || s2_e_reg >= 12'sd11) begin
            q_next = s2_sign_reg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        end else if (s2_tiny_reg || s2_e_reg <= -12'sd54) begin
            q_next = 64'd0;
        end else begin
            q_next = s2_sign_reg ? (~mag + 64'd1) : mag;
        end
    end

    assign s1_valid_next = start;
    assign s2_valid_next = s1_valid_reg;
    assign q_valid_next  = s2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            q_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            q_valid_reg  <= q_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            s1_sign_reg <= value_bits[63];
            s1_exp_reg  <= value_bits[62:52];
            s1_nan_reg  <= (value_bits[62:52] == 11'h7FF) && (value_bits[51:0] != 52'd0);
            s1_inf_reg  <= (value_bits[62:52] == 11'h7FF) && (value_bits[51:0] == 52'd0);
            s1_tiny_reg <= (value_bits[62:52] == 11'h000);
            s1_prod_reg <= prod;
        end
        if (s1_valid_reg) begin
            s2_sign_reg <= s1_sign_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_tiny_reg <= s1_tiny_reg;
            s2_m_reg    <= m_next;
            s2_e_reg    <= e_next;
        end
        if (s2_valid_reg) begin
            q_reg <= q_next;
        end
    end

    assign q_valid = q_valid_reg;
    assign q       = q_reg;

    a_stage2_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |=> s2_valid_reg)
        else $error("Rounding stage did not follow the product stage.");
    a_out_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |=> q_valid_reg)
        else $error("Quantised value did not follow the rounding stage.");
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({s1_valid_reg, s2_valid_reg, q_valid_reg}) <= 1)
        else $error("More than one item inside the quantiser.");

endmodule

/* hdl/qfl_fold.sv */
module qfl_fold (
    input  logic                aclk,
    input  logic                aresetn,
    input  qfl_pkg::fold_cmd_t  cmd,
    output logic                busy,
    output logic                done,
    output logic [63:0]         acc
);
    import qfl_pkg::*;

    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      shift_reg, shift_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb begin
        acc_next   = acc_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (cmd.load) begin
            acc_next   = cmd.first ? FNV_BASIS : acc_reg;
            shift_next = cmd.q;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            acc_next   = fnv_step(acc_reg, shift_reg[7:0]);
            shift_next = shift_reg >> 8;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(BYTES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= FNV_BASIS;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign acc  = acc_reg;

    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !busy_reg)
        else $error("Fold loaded while still working on an item.");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("Fold finished without having been busy.");
    a_acc_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg && !cmd.load |=> $stable(acc_reg))
        else $error("Accumulator changed while the fold was idle.");

endmodule

/* hdl/quantized_fnv1a_log_hash_top.sv */
// An item with last set passes the three-stage quantiser, the fold load, the byte-serial
// FNV fold and the emit state before its hash shows on m_valid. s_ready is high only in
// the idle state, so a new item is accepted only after the previous one has finished.
// An item with last waits longer while an earlier hash is still held on the output.
// Reset (aresetn low, synchronous) loads the offset basis into the accumulator and
// empties the quantiser, the fold and the output register.
module quantized_fnv1a_log_hash_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic        s_first,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_hash
);
    import qfl_pkg::*;

    state_t      state_reg, state_next;
    logic        first_reg, last_reg;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] hash_reg, hash_next;
    logic        accept;
    logic        q_valid;
    logic [63:0] q;
    fold_cmd_t   cmd;
    logic        fold_busy;
    logic        fold_done;
    logic [63:0] acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    qfl_quant u_quant (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .value_bits (s_value_bits),
        .q_valid    (q_valid),
        .q          (q)
    );

    assign cmd.load  = (state_reg == ST_QUANT) && q_valid;
    assign cmd.first = first_reg;
    assign cmd.q     = q;

    qfl_fold u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .busy    (fold_busy),
        .done    (fold_done),
        .acc     (acc)
    );

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        hash_next    = hash_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_QUANT;
                end
            end
            ST_QUANT: begin
                if (q_valid) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (fold_done) begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    hash_next    = acc;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        if (accept) begin
            first_reg <= s_first;
            last_reg  <= s_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hash  = hash_reg;

    a_accept_idle_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !fold_busy && !q_valid)
        else $error("Item accepted while the datapath was still working.");
    a_quant_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> state_reg == ST_QUANT)
        else $error("Quantised value arrived outside the quantise state.");
    a_done_in_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        fold_done |-> state_reg == ST_FOLD)
        else $error("Fold finished outside the fold state.");
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && state_next == ST_IDLE |=> m_valid_reg && hash_reg == $past(acc))
        else $error("Hash not loaded into the output register.");

endmodule
